@@ design/xrbs_pkg.sv @@
package xrbs_pkg;

    localparam int unsigned XRBS_MAX_FILL_BYTES = 512;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned BYTES_W = 4;

    localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESEED   = 2'd2;

    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SM_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SM_MUL_B = 64'h94d049bb133111eb;

    localparam logic [WORD_W-1:0] STATE0_RESET = 64'he220a8397b1dcdaf;
    localparam logic [WORD_W-1:0] STATE1_RESET = 64'h6e789e6aa1b965f4;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_SEED_ADD,
        DP_ACC_ADD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_MIX27,
        DP_STORE0,
        DP_STORE1,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic                mul_b_sel;
        logic [BYTES_W-1:0]  emit_bytes;
        logic                emit_last;
    } t_dp_cmd;

endpackage

@@ design/xoroshiro_random_byte_source.sv @@
// xoroshiro128+ random word source with splitmix64 reseeding. A transfer on the
// input channel carries a command: generate gives one 64-bit word, fill gives one
// word per eight requested bytes (rounded up, length saturating at MAX_FILL_BYTES),
// each tagged with its count of valid low-order bytes and a last mark, and reseed
// reloads both state words from the seed register through two splitmix64 steps.
// A command is taken while the block is idle; the state advances once per word, and
// a generate or fill holds the input until its last word has been issued, and longer
// while the output stalls. A reseed runs its two splitmix64 steps through the single
// shared 32x32 multiplier, which forms each 64-bit splitmix product in three steps.
// The seed register must be written only while the block is idle; the block itself
// does not enforce this, so the user is bound to it.
module xoroshiro_random_byte_source #(
    parameter int unsigned MAX_FILL_BYTES = xrbs_pkg::XRBS_MAX_FILL_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [xrbs_pkg::WORD_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [xrbs_pkg::CMD_W-1:0]    i_command,
    input  logic [xrbs_pkg::LEN_W-1:0]    i_length_bytes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [xrbs_pkg::WORD_W-1:0]   o_random_word,
    output logic [xrbs_pkg::BYTES_W-1:0]  o_valid_bytes,
    output logic                          o_last_word
);
    import xrbs_pkg::*;

    t_dp_cmd dp_cmd;

    xrbs_ctrl #(
        .MAX_FILL_BYTES (MAX_FILL_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_length_bytes (i_length_bytes),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cmd          (dp_cmd)
    );

    xrbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_random_word  (o_random_word),
        .o_valid_bytes  (o_valid_bytes),
        .o_last_word    (o_last_word)
    );

endmodule

@@ design/xrbs_datapath.sv @@
module xrbs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xrbs_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_cfg_wr_en,
    input  logic [xrbs_pkg::WORD_W-1:0]   i_cfg_wr_data,
    output logic [xrbs_pkg::WORD_W-1:0]   o_random_word,
    output logic [xrbs_pkg::BYTES_W-1:0]  o_valid_bytes,
    output logic                          o_last_word
);
    import xrbs_pkg::*;

    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_s0;
    logic [WORD_W-1:0]  r_s1;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_z;
    logic [WORD_W-1:0]  r_p0;
    logic [31:0]        r_p1;
    logic [WORD_W-1:0]  r_out_word;
    logic [BYTES_W-1:0] r_out_bytes;
    logic               r_out_last;

    logic [WORD_W-1:0]  acc_sum;
    logic [WORD_W-1:0]  mul_k;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic [31:0]        cross_sum;
    logic [WORD_W-1:0]  gen_sum;
    logic [WORD_W-1:0]  mix_b;
    logic [WORD_W-1:0]  n_s0;
    logic [WORD_W-1:0]  n_s1;
    logic [WORD_W-1:0]  sm_out;

    assign acc_sum = ((i_cmd.op == DP_SEED_ADD) ? r_seed : r_acc) + SM_GAMMA;

    assign mul_k = i_cmd.mul_b_sel ? SM_MUL_B : SM_MUL_A;
    assign mul_a = (i_cmd.op == DP_MUL2) ? r_z[63:32] : r_z[31:0];
    assign mul_b = (i_cmd.op == DP_MUL1) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    assign cross_sum = r_p1 + mul_p[31:0];

    assign gen_sum = r_s0 + r_s1;
    assign mix_b   = r_s0 ^ r_s1;
    assign n_s0    = {r_s0[8:0], r_s0[63:9]} ^ mix_b ^ (mix_b << 14);
    assign n_s1    = {mix_b[27:0], mix_b[63:28]};

    assign sm_out = r_z ^ (r_z >> 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_s0   <= STATE0_RESET;
            r_s1   <= STATE1_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            case (i_cmd.op)
                DP_EMIT: begin
                    r_s0 <= n_s0;
                    r_s1 <= n_s1;
                end
                DP_STORE0: r_s0 <= sm_out;
                DP_STORE1: r_s1 <= sm_out;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_SEED_ADD, DP_ACC_ADD: begin
                r_acc <= acc_sum;
                r_z   <= acc_sum ^ (acc_sum >> 30);
            end
            DP_MUL0: r_p0 <= mul_p;
            DP_MUL1: r_p1 <= mul_p[31:0];
            DP_MUL2: r_z  <= r_p0 + {cross_sum, 32'b0};
            DP_MIX27: r_z <= r_z ^ (r_z >> 27);
            DP_EMIT: begin
                r_out_word  <= gen_sum;
                r_out_bytes <= i_cmd.emit_bytes;
                r_out_last  <= i_cmd.emit_last;
            end
            default: ;
        endcase
    end

    assign o_random_word = r_out_word;
    assign o_valid_bytes = r_out_bytes;
    assign o_last_word   = r_out_last;

endmodule

@@ design/xrbs_ctrl.sv @@
module xrbs_ctrl #(
    parameter int unsigned MAX_FILL_BYTES = xrbs_pkg::XRBS_MAX_FILL_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [xrbs_pkg::CMD_W-1:0]    i_command,
    input  logic [xrbs_pkg::LEN_W-1:0]    i_length_bytes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output xrbs_pkg::t_dp_cmd             o_cmd
);
    import xrbs_pkg::*;

    localparam int unsigned REM_W = $clog2(MAX_FILL_BYTES + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FILL_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_SM_ADD,
        S_MA0,
        S_MA1,
        S_MA2,
        S_MIX,
        S_MB0,
        S_MB1,
        S_MB2,
        S_STORE
    } t_state;

    t_state             r_state, n_state;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic               r_round, n_round;
    logic               r_out_valid, n_out_valid;

    logic [REM_W-1:0]   sat_len;
    logic [BYTES_W-1:0] take;
    logic               is_last;

    assign sat_len = (i_length_bytes > MAX_LEN) ? REM_W'(MAX_FILL_BYTES)
                                                : REM_W'(i_length_bytes);
    assign take    = (r_rem >= REM_W'(8)) ? BYTES_W'(8) : BYTES_W'(r_rem);
    assign is_last = (r_rem <= REM_W'(8));

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        o_cmd       = '{op: DP_NOP, mul_b_sel: 1'b0, emit_bytes: take, emit_last: is_last};

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_GENERATE: begin
                            n_rem   = REM_W'(8);
                            n_state = S_EMIT;
                        end
                        CMD_FILL: begin
                            if (sat_len != '0) begin
                                n_rem   = sat_len;
                                n_state = S_EMIT;
                            end
                        end
                        CMD_RESEED: begin
                            n_round = 1'b0;
                            n_state = S_SM_ADD;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_rem       = r_rem - REM_W'(take);
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SM_ADD: begin
                o_cmd.op = r_round ? DP_ACC_ADD : DP_SEED_ADD;
                n_state  = S_MA0;
            end
            S_MA0: begin
                o_cmd.op = DP_MUL0;
                n_state  = S_MA1;
            end
            S_MA1: begin
                o_cmd.op = DP_MUL1;
                n_state  = S_MA2;
            end
            S_MA2: begin
                o_cmd.op = DP_MUL2;
                n_state  = S_MIX;
            end
            S_MIX: begin
                o_cmd.op = DP_MIX27;
                n_state  = S_MB0;
            end
            S_MB0: begin
                o_cmd.op        = DP_MUL0;
                o_cmd.mul_b_sel = 1'b1;
                n_state         = S_MB1;
            end
            S_MB1: begin
                o_cmd.op        = DP_MUL1;
                o_cmd.mul_b_sel = 1'b1;
                n_state         = S_MB2;
            end
            S_MB2: begin
                o_cmd.op        = DP_MUL2;
                o_cmd.mul_b_sel = 1'b1;
                n_state         = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = r_round ? DP_STORE1 : DP_STORE0;
                if (r_round) begin
                    n_state = S_IDLE;
                end else begin
                    n_round = 1'b1;
                    n_state = S_SM_ADD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rem       <= '0;
            r_round     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ dv/tb_xoroshiro_random_byte_source.sv @@
module tb_xoroshiro_random_byte_source;
    import xrbs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [BYTES_W-1:0] bytes;
        logic               last;
    } t_word_rec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [WORD_W-1:0]   i_cfg_wr_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [CMD_W-1:0]    i_command = CMD_GENERATE;
    logic [LEN_W-1:0]    i_length_bytes = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [WORD_W-1:0]   o_random_word;
    logic [BYTES_W-1:0]  o_valid_bytes;
    logic                o_last_word;

    t_word_rec           pending_words[$];
    logic [WORD_W-1:0]   gen_s0;
    logic [WORD_W-1:0]   gen_s1;
    logic [WORD_W-1:0]   seed_reg;
    int unsigned         fail_count = 0;
    int                  rx_hold_cycles = 0;
    bit                  send_idle = 1'b1;
    bit                  recv_idle = 1'b1;

    xoroshiro_random_byte_source u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_length_bytes (i_length_bytes),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_word  (o_random_word),
        .o_valid_bytes  (o_valid_bytes),
        .o_last_word    (o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] splitmix_mix(input logic [WORD_W-1:0] acc);
        logic [WORD_W-1:0] z;
        z = acc;
        z = (z ^ (z >> 30)) * SM_MUL_A;
        z = (z ^ (z >> 27)) * SM_MUL_B;
        return z ^ (z >> 31);
    endfunction

    task automatic load_state_from(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] acc;
        acc = seed + SM_GAMMA;
        gen_s0 = splitmix_mix(acc);
        acc = acc + SM_GAMMA;
        gen_s1 = splitmix_mix(acc);
    endtask

    task automatic push_next_word(input int nbytes, input bit is_last);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        t_word_rec rec;
        a = gen_s0;
        b = gen_s1;
        rec.word = a + b;
        rec.bytes = BYTES_W'(nbytes);
        rec.last = is_last;
        b = b ^ a;
        gen_s0 = {a[8:0], a[63:9]} ^ b ^ (b << 14);
        gen_s1 = {b[27:0], b[63:28]};
        pending_words.push_back(rec);
    endtask

    task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len);
        int remaining;
        int take;
        case (cmd)
            CMD_GENERATE: begin
                push_next_word(8, 1'b1);
            end
            CMD_FILL: begin
                remaining = (len > XRBS_MAX_FILL_BYTES) ? XRBS_MAX_FILL_BYTES : int'(len);
                while (remaining > 0) begin
                    take = (remaining >= 8) ? 8 : remaining;
                    remaining -= take;
                    push_next_word(take, remaining == 0);
                end
            end
            CMD_RESEED: begin
                load_state_from(seed_reg);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : check_words
        t_word_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %h bytes %0d last %0b",
                         $time, o_random_word, o_valid_bytes, o_last_word);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_random_word !== want.word) begin
                    $display("%0t: random_word mismatch: expected %h, actual %h",
                             $time, want.word, o_random_word);
                    fail_count++;
                end
                if (o_valid_bytes !== want.bytes) begin
                    $display("%0t: valid_bytes mismatch: expected %0d, actual %0d",
                             $time, want.bytes, o_valid_bytes);
                    fail_count++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last_word mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    initial begin : result_sink
        int gap;
        forever begin
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = recv_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len);
        int gap;
        gap = send_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_length_bytes <= len;
        do @(posedge i_clk); while (!o_ready);
        predict_command(cmd, len);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        seed_reg = value;
    endtask

    task automatic test_reset_state();
        send_command(CMD_GENERATE, '0);
        send_command(CMD_GENERATE, '1);
        send_command(CMD_FILL, '0);
        send_command(CMD_GENERATE, 10'd5);
    endtask

    task automatic test_fill_lengths();
        send_command(CMD_FILL, 10'd1);
        send_command(CMD_FILL, 10'd7);
        send_command(CMD_FILL, 10'd8);
        send_command(CMD_FILL, 10'd9);
        send_command(CMD_FILL, 10'd15);
        send_command(CMD_FILL, 10'd16);
        send_command(CMD_FILL, 10'd17);
        send_command(CMD_FILL, 10'd512);
        send_command(CMD_FILL, 10'd513);
        send_command(CMD_FILL, 10'd1023);
    endtask

    task automatic test_unused_code();
        send_command(CMD_UNUSED, '1);
        send_command(CMD_UNUSED, '0);
        send_command(CMD_GENERATE, '0);
    endtask

    task automatic test_reseed_extremes();
        write_seed('1);
        send_command(CMD_RESEED, '1);
        send_command(CMD_GENERATE, '0);
        send_command(CMD_FILL, 10'd20);
        write_seed('0);
        send_command(CMD_RESEED, '0);
        send_command(CMD_GENERATE, '0);
    endtask

    // The sink stops taking words for a long stretch while commands keep coming.
    task automatic test_output_stall();
        wait_drained();
        send_idle = 1'b0;
        rx_hold_cycles = 300;
        send_command(CMD_FILL, 10'd24);
        send_command(CMD_GENERATE, '0);
        send_command(CMD_FILL, 10'd40);
        send_command(CMD_FILL, 10'd3);
        send_command(CMD_GENERATE, '0);
        send_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_command(CMD_FILL, 10'd12);
        send_command(CMD_GENERATE, '0);
        wait_drained();
        send_command(CMD_GENERATE, '0);
        send_command(CMD_FILL, 10'd33);
    endtask

    task automatic test_random_phase(input logic [WORD_W-1:0] seed, input int n_items,
                                     input bit tx_idle, input bit rx_idle);
        int count;
        int r;
        logic [CMD_W-1:0] cmd;
        logic [LEN_W-1:0] len;
        write_seed(seed);
        send_idle = tx_idle;
        recv_idle = rx_idle;
        send_command(CMD_RESEED, LEN_W'($urandom));
        count = 1;
        while (count < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 35) cmd = CMD_GENERATE;
            else if (r < 80) cmd = CMD_FILL;
            else if (r < 92) cmd = CMD_RESEED;
            else cmd = CMD_UNUSED;
            r = $urandom_range(0, 99);
            if (cmd != CMD_FILL) len = LEN_W'($urandom);
            else if (r < 70) len = LEN_W'($urandom_range(0, 24));
            else if (r < 90) len = LEN_W'($urandom_range(25, 64));
            else if (r < 97) len = LEN_W'($urandom_range(65, 512));
            else len = LEN_W'($urandom_range(513, 1023));
            send_command(cmd, len);
            if (cmd != CMD_UNUSED) count++;
        end
    endtask

    initial begin
        seed_reg = '0;
        load_state_from('0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_fill_lengths();
        test_unused_code();
        test_reseed_extremes();
        test_output_stall();
        test_sender_pause();
        test_random_phase('0, 55, 1'b1, 1'b1);
        test_random_phase('1, 55, 1'b0, 1'b0);
        test_random_phase({$urandom, $urandom}, 55, 1'b1, 1'b0);
        test_random_phase({$urandom, $urandom}, 55, 1'b0, 1'b1);
        test_random_phase(64'h1, 55, 1'b1, 1'b1);
        test_random_phase({$urandom, $urandom}, 55, 1'b1, 1'b1);
        wait_drained();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/xrbs_pkg.sv
design/xrbs_datapath.sv
design/xrbs_ctrl.sv
design/xoroshiro_random_byte_source.sv
dv/tb_xoroshiro_random_byte_source.sv
